// ----- design/dqsd_pkg.sv -----
// ============================================================================
// dqsd_pkg: shared types and constants of the deque with search and delete
// Operation codes, status codes, cell commands and controller states.
// ============================================================================
`default_nettype none

package dqsd_pkg;

   localparam int DATA_W   = 32;
   localparam int MODE_W   = 3;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;
   localparam int OCC_W    = 5;

   typedef enum logic [MODE_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SEARCH     = 3'd4,
      OP_DELETE     = 3'd5,
      OP_CLEAR      = 3'd6,
      OP_READ_OUT   = 3'd7
   } req_op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   // Command broadcast to every storage cell.
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_SHIFT_RIGHT,
      CELL_SHIFT_LEFT,
      CELL_LOAD
   } cell_op_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_CLOSE
   } fsm_state_type;

endpackage

`default_nettype wire

// ----- design/dqsd_cell.sv -----
// ============================================================================
// dqsd_cell: one storage cell of the deque chain
// Holds one entry and takes its neighbor's entry or the pushed value on command.
// ============================================================================
`default_nettype none

module dqsd_cell (
   input  wire logic                         clock,
   input  wire dqsd_pkg::cell_op_type        op,
   input  wire logic                         sel,
   input  wire logic [dqsd_pkg::DATA_W-1:0]  left_data,
   input  wire logic [dqsd_pkg::DATA_W-1:0]  right_data,
   input  wire logic [dqsd_pkg::DATA_W-1:0]  load_data,
   output logic      [dqsd_pkg::DATA_W-1:0]  data_out
);

   logic [dqsd_pkg::DATA_W-1:0] data_ff;
   logic [dqsd_pkg::DATA_W-1:0] data_in;

   // Shift left and load act only on the cells that the controller selects.
   always_comb begin
      data_in = data_ff;
      unique case (op)
         dqsd_pkg::CELL_HOLD:        data_in = data_ff;
         dqsd_pkg::CELL_SHIFT_RIGHT: data_in = left_data;
         dqsd_pkg::CELL_SHIFT_LEFT:  data_in = sel ? right_data : data_ff;
         dqsd_pkg::CELL_LOAD:        data_in = sel ? load_data : data_ff;
         default:                    data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

`default_nettype wire

// ----- design/deque_with_search_delete_core.sv -----
// ============================================================================
// deque_with_search_delete_core: bounded double-ended queue with search/delete
// A chain of storage cells kept in queue order, driven by a small controller.
// ============================================================================
// Usage:
//   A transaction is accepted at a rising edge with start high and busy low.
//   req_mode selects push front/back, pop front/back, search, delete, clear or
//   read out; req_value carries the operand.
//   Each result is shown for one cycle with rsp_strobe high; rsp_last marks
//   the final result of a transaction. The receiver cannot stall the block.
// Busy and results:
//   Push, pop and clear, and any operation rejected as full or empty, answer
//   in the cycle after acceptance and never raise busy, so one such
//   transaction can be taken every cycle.
//   Search, delete and read out rotate the whole cell chain once, one cell per
//   cycle, and keep busy high during that pass. Read out emits one result per
//   entry during that pass. A delete that finds its match then closes the gap.
// Reset:
//   Reset empties the queue and drops any result in flight. Cell contents are
//   not cleared; entries beyond the occupancy are never shown.
// ============================================================================
`default_nettype none

module deque_with_search_delete_core #(
   parameter int DEPTH = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic        [dqsd_pkg::MODE_W-1:0] req_mode,
   input  wire logic signed [dqsd_pkg::DATA_W-1:0] req_value,
   output logic                                    rsp_strobe,
   output logic        [dqsd_pkg::STATUS_W-1:0]    rsp_status,
   output logic signed [dqsd_pkg::DATA_W-1:0]      rsp_value_out,
   output logic        [dqsd_pkg::POS_W-1:0]       rsp_position,
   output logic        [dqsd_pkg::OCC_W-1:0]       rsp_occupancy,
   output logic                                    rsp_last
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = dqsd_pkg::DATA_W;
   localparam int POS_W  = dqsd_pkg::POS_W;
   localparam int OCC_W  = dqsd_pkg::OCC_W;

   // Controller state.
   dqsd_pkg::fsm_state_type state_ff, state_in;
   dqsd_pkg::req_op_type    op_ff, op_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        step_ff, step_in;
   logic                    found_ff, found_in;
   logic [IDX_W-1:0]        match_ff, match_in;
   logic [DATA_W-1:0]       key_ff, key_in;

   // Result register.
   logic                    rsp_strobe_ff, rsp_strobe_in;
   dqsd_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]        rsp_position_ff, rsp_position_in;
   logic [OCC_W-1:0]        rsp_occupancy_ff, rsp_occupancy_in;
   logic                    rsp_last_ff, rsp_last_in;

   // Cell chain controls and contents. Cell 0 holds the front entry while idle.
   dqsd_pkg::cell_op_type   cell_op;
   logic [IDX_W-1:0]        shift_from;
   logic [DEPTH-1:0]        cell_sel;
   logic [DATA_W-1:0]       cell_q [DEPTH];

   logic                    accept;
   logic                    is_empty;
   logic                    is_full;
   logic [CNT_W-1:0]        count_dec;
   logic                    in_range;
   logic                    hit;
   logic [IDX_W-1:0]        pos_base;

   assign busy      = (state_ff != dqsd_pkg::FSM_IDLE);
   assign accept    = start && !busy;
   assign is_empty  = (count_ff == '0);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign count_dec = count_ff - CNT_W'(1);

   // During a scan the entry at the front is the one at logical position step.
   assign in_range = (CNT_W'(step_ff) < count_ff);
   assign hit      = in_range && !found_ff && (cell_q[0] == key_ff);
   assign pos_base = found_ff ? match_ff : step_ff;

   // ------------------------------------------------------------------------
   // Cell chain. Shifting left with a wrap from the last cell to cell 0 is a
   // rotation when every cell is selected; with a start index above zero it
   // closes the gap left by a deleted entry.
   // ------------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int RIGHT = (i + 1) % DEPTH;
      logic [DATA_W-1:0] left_data;

      if (i == 0) begin : g_head
         assign left_data = req_value;
      end else begin : g_body
         assign left_data = cell_q[i-1];
      end

      assign cell_sel[i] = (cell_op == dqsd_pkg::CELL_LOAD) ?
                           (CNT_W'(i) == count_ff) : (IDX_W'(i) >= shift_from);

      dqsd_cell u_cell (
         .clock      (clock),
         .op         (cell_op),
         .sel        (cell_sel[i]),
         .left_data  (left_data),
         .right_data (cell_q[RIGHT]),
         .load_data  (req_value),
         .data_out   (cell_q[i])
      );
   end

   // ------------------------------------------------------------------------
   // Controller: next state, cell commands and the next result.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in         = state_ff;
      op_in            = op_ff;
      count_in         = count_ff;
      step_in          = step_ff;
      found_in         = found_ff;
      match_in         = match_ff;
      key_in           = key_ff;
      cell_op          = dqsd_pkg::CELL_HOLD;
      shift_from       = '0;
      rsp_strobe_in    = 1'b0;
      rsp_status_in    = dqsd_pkg::STAT_OK;
      rsp_value_in     = '0;
      rsp_position_in  = '0;
      rsp_last_in      = 1'b1;

      unique case (state_ff)
         dqsd_pkg::FSM_IDLE: begin
            if (accept) begin
               op_in    = dqsd_pkg::req_op_type'(req_mode);
               key_in   = req_value;
               step_in  = '0;
               found_in = 1'b0;
               match_in = '0;
               unique case (dqsd_pkg::req_op_type'(req_mode))
                  dqsd_pkg::OP_PUSH_FRONT, dqsd_pkg::OP_PUSH_BACK: begin
                     rsp_strobe_in = 1'b1;
                     if (is_full) begin
                        rsp_status_in = dqsd_pkg::STAT_FULL;
                     end else begin
                        cell_op  = (dqsd_pkg::req_op_type'(req_mode) ==
                                    dqsd_pkg::OP_PUSH_FRONT) ?
                                   dqsd_pkg::CELL_SHIFT_RIGHT : dqsd_pkg::CELL_LOAD;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  dqsd_pkg::OP_POP_FRONT, dqsd_pkg::OP_POP_BACK: begin
                     rsp_strobe_in = 1'b1;
                     if (is_empty) begin
                        rsp_status_in = dqsd_pkg::STAT_EMPTY;
                     end else if (dqsd_pkg::req_op_type'(req_mode) ==
                                  dqsd_pkg::OP_POP_FRONT) begin
                        rsp_value_in = cell_q[0];
                        cell_op      = dqsd_pkg::CELL_SHIFT_LEFT;
                        count_in     = count_dec;
                     end else begin
                        rsp_value_in = cell_q[count_dec[IDX_W-1:0]];
                        count_in     = count_dec;
                     end
                  end
                  dqsd_pkg::OP_SEARCH, dqsd_pkg::OP_DELETE, dqsd_pkg::OP_READ_OUT: begin
                     if (is_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = dqsd_pkg::STAT_EMPTY;
                     end else begin
                        state_in = dqsd_pkg::FSM_SCAN;
                     end
                  end
                  dqsd_pkg::OP_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     count_in      = '0;
                  end
               endcase
            end
         end

         dqsd_pkg::FSM_SCAN: begin
            // One rotation step per cycle; DEPTH steps restore the order.
            cell_op = dqsd_pkg::CELL_SHIFT_LEFT;
            step_in = step_ff + IDX_W'(1);
            if (hit) begin
               found_in = 1'b1;
               match_in = step_ff;
            end
            if (op_ff == dqsd_pkg::OP_READ_OUT && in_range) begin
               rsp_strobe_in   = 1'b1;
               rsp_value_in    = cell_q[0];
               rsp_position_in = POS_W'(CNT_W'(step_ff) + CNT_W'(1));
               rsp_last_in     = (CNT_W'(step_ff) + CNT_W'(1) == count_ff);
            end
            if (step_ff == IDX_W'(DEPTH - 1)) begin
               state_in = dqsd_pkg::FSM_IDLE;
               if (op_ff == dqsd_pkg::OP_SEARCH) begin
                  rsp_strobe_in = 1'b1;
                  if (found_ff || hit) begin
                     rsp_position_in = POS_W'(CNT_W'(pos_base) + CNT_W'(1));
                  end else begin
                     rsp_status_in = dqsd_pkg::STAT_NOT_FOUND;
                  end
               end else if (op_ff == dqsd_pkg::OP_DELETE) begin
                  if (found_ff || hit) begin
                     state_in = dqsd_pkg::FSM_CLOSE;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = dqsd_pkg::STAT_NOT_FOUND;
                  end
               end
            end
         end

         dqsd_pkg::FSM_CLOSE: begin
            // Entries behind the deleted one move one cell toward the front.
            cell_op       = dqsd_pkg::CELL_SHIFT_LEFT;
            shift_from    = match_ff;
            count_in      = count_dec;
            rsp_strobe_in = 1'b1;
            rsp_value_in  = key_ff;
            state_in      = dqsd_pkg::FSM_IDLE;
         end

         default: begin
            state_in = dqsd_pkg::FSM_IDLE;
         end
      endcase

      rsp_occupancy_in = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dqsd_pkg::FSM_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      step_ff          <= step_in;
      found_ff         <= found_in;
      match_ff         <= match_in;
      key_ff           <= key_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_value_ff     <= rsp_value_in;
      rsp_position_ff  <= rsp_position_in;
      rsp_occupancy_ff <= rsp_occupancy_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_occupancy = rsp_occupancy_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

// ----- design/dqsd_checker.sv -----
// ============================================================================
// dqsd_checker: port-level checks of the deque core
// Relates accepted transactions, busy and the result strobe over time.
// ============================================================================
`default_nettype none

module dqsd_checker #(
   parameter int DEPTH = 16
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               start,
   input wire logic                               busy,
   input wire logic                               rsp_strobe,
   input wire logic        [dqsd_pkg::OCC_W-1:0]  rsp_occupancy,
   input wire logic                               rsp_last
);

   // An accepted transaction either answers at once or keeps the block busy.
   a_accept_answered: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe || busy)
      else $error("accepted transaction neither answered nor busy");

   // An idle block with no new transaction produces no result next cycle.
   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> !rsp_strobe)
      else $error("result without a transaction");

   // More results of the same transaction follow, so the block is still busy.
   a_more_results_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("non-final result while idle");

   // Occupancy never exceeds the capacity (when it fits the field).
   a_occupancy_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (DEPTH < 32) |-> (int'(rsp_occupancy) <= DEPTH))
      else $error("occupancy beyond capacity");

endmodule

bind deque_with_search_delete_core dqsd_checker #(.DEPTH(DEPTH)) u_dqsd_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// ============================================================================
// tb: self-checking bench for deque_with_search_delete_core
// Drives push, pop, search, delete, clear and read out transactions through
// the start/busy command port and checks every strobed reply against a shadow
// deque kept in the bench. A short scripted part covers empty cases,
// the extreme values and every operation; random phases with different sender
// idle rates follow, each starting with a burst that fills the queue.
// ============================================================================
`default_nettype none

module tb;

   localparam int DEPTH      = 16;
   localparam int QUIET_MAX  = 2000;  // cycles with no transaction and no reply
   localparam int RAND_ITEMS = 60;    // random transactions per idle phase

   // One reply as it appears on the rsp_ ports.
   typedef struct packed {
      dqsd_pkg::status_type status;
      logic signed [31:0]   value;
      logic [4:0]           position;
      logic [4:0]           occupancy;
      logic                 last;
   } reply_type;

   // One row of the scripted part. When pinned is set, the reply is typed into
   // the row and used instead of the shadow deque's answer.
   typedef struct packed {
      dqsd_pkg::req_op_type op;
      logic signed [31:0]   operand;
      logic                 pinned;
      reply_type            reply;
   } script_row_type;

   logic                                 clock;
   logic                                 reset     = 1'b1;
   logic                                 start     = 1'b0;
   logic [dqsd_pkg::MODE_W-1:0]          req_mode  = '0;
   logic signed [dqsd_pkg::DATA_W-1:0]   req_value = '0;
   logic                                 busy;
   logic                                 rsp_strobe;
   logic [dqsd_pkg::STATUS_W-1:0]        rsp_status;
   logic signed [dqsd_pkg::DATA_W-1:0]   rsp_value_out;
   logic [dqsd_pkg::POS_W-1:0]           rsp_position;
   logic [dqsd_pkg::OCC_W-1:0]           rsp_occupancy;
   logic                                 rsp_last;

   // The bench's own copy of the queue contents, front at index 0.
   logic signed [31:0] shadow_deque[$];
   // Replies the shadow deque has produced for the latest transaction.
   reply_type          fresh_replies[$];
   // Replies still owed by the block, oldest first.
   reply_type          owed_replies[$];
   script_row_type     script[$];

   int errors       = 0;
   int items_sent   = 0;
   int replies_seen = 0;
   int full_rejects = 0;
   int read_outs    = 0;
   int quiet_cycles = 0;

   deque_with_search_delete_core #(.DEPTH(DEPTH)) dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Records one reply of the shadow deque. Occupancy is taken after the
   // operation has been applied, as the block reports it.
   function automatic void note_reply(input dqsd_pkg::status_type status,
                                      input logic signed [31:0] value,
                                      input int position, input bit last);
      reply_type r;
      r.status    = status;
      r.value     = value;
      r.position  = 5'(position);
      r.occupancy = 5'(shadow_deque.size());
      r.last      = last;
      fresh_replies.push_back(r);
   endfunction

   // Applies one accepted transaction to the shadow deque and lists the
   // replies it must cause in fresh_replies.
   function automatic void shadow_step(input dqsd_pkg::req_op_type op,
                                       input logic signed [31:0] operand);
      int hit;
      int i;
      logic signed [31:0] got;
      fresh_replies.delete();
      hit = -1;
      for (i = 0; i < shadow_deque.size(); i++)
         if (hit < 0 && shadow_deque[i] == operand)
            hit = i;
      case (op)
         dqsd_pkg::OP_PUSH_FRONT, dqsd_pkg::OP_PUSH_BACK: begin
            if (shadow_deque.size() >= DEPTH) begin
               full_rejects++;
               note_reply(dqsd_pkg::STAT_FULL, 0, 0, 1'b1);
            end else begin
               if (op == dqsd_pkg::OP_PUSH_FRONT) shadow_deque.push_front(operand);
               else shadow_deque.push_back(operand);
               note_reply(dqsd_pkg::STAT_OK, 0, 0, 1'b1);
            end
         end
         dqsd_pkg::OP_POP_FRONT, dqsd_pkg::OP_POP_BACK: begin
            if (shadow_deque.size() == 0) begin
               note_reply(dqsd_pkg::STAT_EMPTY, 0, 0, 1'b1);
            end else begin
               if (op == dqsd_pkg::OP_POP_FRONT) got = shadow_deque.pop_front();
               else got = shadow_deque.pop_back();
               note_reply(dqsd_pkg::STAT_OK, got, 0, 1'b1);
            end
         end
         dqsd_pkg::OP_SEARCH: begin
            if (shadow_deque.size() == 0) note_reply(dqsd_pkg::STAT_EMPTY, 0, 0, 1'b1);
            else if (hit < 0) note_reply(dqsd_pkg::STAT_NOT_FOUND, 0, 0, 1'b1);
            else note_reply(dqsd_pkg::STAT_OK, 0, hit + 1, 1'b1);
         end
         dqsd_pkg::OP_DELETE: begin
            // Delete takes out the first match only; the rest keep their order.
            if (shadow_deque.size() == 0) begin
               note_reply(dqsd_pkg::STAT_EMPTY, 0, 0, 1'b1);
            end else if (hit < 0) begin
               note_reply(dqsd_pkg::STAT_NOT_FOUND, 0, 0, 1'b1);
            end else begin
               got = shadow_deque[hit];
               shadow_deque.delete(hit);
               note_reply(dqsd_pkg::STAT_OK, got, 0, 1'b1);
            end
         end
         dqsd_pkg::OP_CLEAR: begin
            shadow_deque.delete();
            note_reply(dqsd_pkg::STAT_OK, 0, 0, 1'b1);
         end
         default: begin
            // Read out lists the entries front to back, one reply each; an
            // empty queue gives a single empty status instead.
            read_outs++;
            if (shadow_deque.size() == 0)
               note_reply(dqsd_pkg::STAT_EMPTY, 0, 0, 1'b1);
            else
               for (i = 0; i < shadow_deque.size(); i++)
                  note_reply(dqsd_pkg::STAT_OK, shadow_deque[i], i + 1,
                             i + 1 == shadow_deque.size());
         end
      endcase
   endfunction

   function automatic void add_row(input dqsd_pkg::req_op_type op,
                                   input logic signed [31:0] operand,
                                   input bit pinned,
                                   input dqsd_pkg::status_type status,
                                   input int occupancy);
      script_row_type row;
      row.op              = op;
      row.operand         = operand;
      row.pinned          = pinned;
      row.reply.status    = status;
      row.reply.value     = '0;
      row.reply.position  = '0;
      row.reply.occupancy = 5'(occupancy);
      row.reply.last      = 1'b1;
      script.push_back(row);
   endfunction

   // Random operation mix. Pushes slightly outweigh removals, so the queue
   // drifts toward full and rejected pushes keep showing up.
   function automatic dqsd_pkg::req_op_type draw_op();
      int r;
      r = $urandom_range(99);
      if (r < 22) return dqsd_pkg::OP_PUSH_FRONT;
      if (r < 44) return dqsd_pkg::OP_PUSH_BACK;
      if (r < 56) return dqsd_pkg::OP_POP_FRONT;
      if (r < 68) return dqsd_pkg::OP_POP_BACK;
      if (r < 78) return dqsd_pkg::OP_SEARCH;
      if (r < 90) return dqsd_pkg::OP_DELETE;
      if (r < 97) return dqsd_pkg::OP_READ_OUT;
      return dqsd_pkg::OP_CLEAR;
   endfunction

   // Searches and deletes mostly name a value that is present, so the scan
   // finds real matches at all depths. A small pool of values makes duplicates
   // common, which tests that only the first match counts. Full-width random
   // values toggle every bit of the operand.
   function automatic logic signed [31:0] draw_value(input dqsd_pkg::req_op_type op);
      int r;
      r = $urandom_range(9);
      if ((op == dqsd_pkg::OP_SEARCH || op == dqsd_pkg::OP_DELETE) &&
          shadow_deque.size() != 0 && r < 7)
         return shadow_deque[$urandom_range(shadow_deque.size() - 1)];
      if (r < 5) return 32'($urandom_range(7)) - 32'd4;
      return $urandom;
   endfunction

   // Presents one transaction and holds it until the block takes it. Start is
   // left high on return so back-to-back transactions need no second write to
   // it in the same time step.
   task automatic run_op(input script_row_type row);
      start     <= 1'b1;
      req_mode  <= row.op;
      req_value <= row.operand;
      @(posedge clock);
      while (busy) @(posedge clock);
      shadow_step(row.op, row.operand);
      if (row.pinned) owed_replies.push_back(row.reply);
      else foreach (fresh_replies[i]) owed_replies.push_back(fresh_replies[i]);
      items_sent++;
   endtask

   task automatic run_random(input dqsd_pkg::req_op_type op);
      script_row_type row;
      row         = '0;
      row.op      = op;
      row.operand = draw_value(op);
      run_op(row);
   endtask

   // Idles the sender for a random stretch; each cycle is idle with the
   // given percentage. Junk on the request fields must be ignored.
   task automatic sender_gap(input int pct);
      if (pct != 0 && $urandom_range(99) < pct) begin
         start     <= 1'b0;
         req_mode  <= 3'($urandom);
         req_value <= $urandom;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   // Holds the sender off until every owed reply has come back.
   task automatic drain_replies();
      start <= 1'b0;
      do @(posedge clock); while (owed_replies.size() != 0);
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Reply checker. The receiver cannot stall, so every strobe is a reply
   // that must match the oldest one owed.
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         replies_seen++;
         if (owed_replies.size() == 0) begin
            errors++;
            $display("%0t: unexpected reply, expected none, actual status %0d value %0h",
                     $time, rsp_status, rsp_value_out);
         end else begin
            want = owed_replies.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("value_out", want.value, rsp_value_out);
            check_field("position", 32'(want.position), 32'(rsp_position));
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
            check_field("last", 32'(want.last), 32'(rsp_last));
         end
      end
   end

   // Watchdog: a long stretch with no transaction taken and no reply means
   // the block has hung.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("%0t: no progress for %0d cycles", $time, QUIET_MAX);
         $display("[deque_with_search_delete_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase;
      int n;
      int pct;
      dqsd_pkg::req_op_type op;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Scripted part: every error status on an empty queue, the extreme
      // values at both ends, a duplicate so search and delete must pick the
      // first match, and read out before and after a clear.
      add_row(dqsd_pkg::OP_POP_FRONT,  32'sd5,         1'b1, dqsd_pkg::STAT_EMPTY,     0);
      add_row(dqsd_pkg::OP_POP_BACK,   32'sd5,         1'b1, dqsd_pkg::STAT_EMPTY,     0);
      add_row(dqsd_pkg::OP_SEARCH,     32'sd5,         1'b1, dqsd_pkg::STAT_EMPTY,     0);
      add_row(dqsd_pkg::OP_DELETE,     32'sd5,         1'b1, dqsd_pkg::STAT_EMPTY,     0);
      add_row(dqsd_pkg::OP_READ_OUT,   32'sd0,         1'b1, dqsd_pkg::STAT_EMPTY,     0);
      add_row(dqsd_pkg::OP_PUSH_BACK,  32'sh7FFF_FFFF, 1'b1, dqsd_pkg::STAT_OK,        1);
      add_row(dqsd_pkg::OP_PUSH_FRONT, 32'sh8000_0000, 1'b1, dqsd_pkg::STAT_OK,        2);
      add_row(dqsd_pkg::OP_PUSH_BACK,  32'sd0,         1'b1, dqsd_pkg::STAT_OK,        3);
      add_row(dqsd_pkg::OP_PUSH_FRONT, -32'sd1,        1'b1, dqsd_pkg::STAT_OK,        4);
      add_row(dqsd_pkg::OP_PUSH_BACK,  32'sh7FFF_FFFF, 1'b1, dqsd_pkg::STAT_OK,        5);
      add_row(dqsd_pkg::OP_SEARCH,     32'sh7FFF_FFFF, 1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_SEARCH,     32'sd42,        1'b1, dqsd_pkg::STAT_NOT_FOUND, 5);
      add_row(dqsd_pkg::OP_DELETE,     32'sd42,        1'b1, dqsd_pkg::STAT_NOT_FOUND, 5);
      add_row(dqsd_pkg::OP_READ_OUT,   32'sd0,         1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_DELETE,     32'sh7FFF_FFFF, 1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_READ_OUT,   32'sd0,         1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_POP_BACK,   32'sd0,         1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_POP_FRONT,  32'sd0,         1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_PUSH_FRONT, 32'sh5555_5555, 1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_PUSH_BACK,  32'shAAAA_AAAA, 1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_SEARCH,     -32'sd1,        1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_DELETE,     32'sh8000_0000, 1'b0, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_CLEAR,      32'sd0,         1'b1, dqsd_pkg::STAT_OK,        0);
      add_row(dqsd_pkg::OP_READ_OUT,   32'sd0,         1'b1, dqsd_pkg::STAT_EMPTY,     0);
      add_row(dqsd_pkg::OP_POP_BACK,   32'sd0,         1'b1, dqsd_pkg::STAT_EMPTY,     0);

      foreach (script[i]) begin
         run_op(script[i]);
         sender_gap(20);
      end
      drain_replies();

      // Random phases: no sender idling, idle 53 percent of cycles, then 20.
      // Each starts by filling the queue from random ends and pushing past
      // full, so rejected pushes into a full queue are checked as well.
      for (phase = 0; phase < 3; phase++) begin
         pct = (phase == 0) ? 0 : (phase == 1) ? 53 : 20;
         while (shadow_deque.size() < DEPTH + 2) begin
            run_random($urandom_range(1) ? dqsd_pkg::OP_PUSH_BACK
                                         : dqsd_pkg::OP_PUSH_FRONT);
            sender_gap(pct);
            if (fresh_replies[0].status == dqsd_pkg::STAT_FULL && $urandom_range(1))
               break;
         end
         for (n = 0; n < RAND_ITEMS; n++) begin
            op = draw_op();
            run_random(op);
            sender_gap(pct);
         end
         // Let the block finish everything before the next idle setting.
         drain_replies();
      end

      // Every reply is in; the extra wait catches any stray strobe.
      repeat (DEPTH + 4) @(posedge clock);
      if (owed_replies.size() != 0) begin
         errors++;
         $display("%0t: %0d replies never arrived, expected 0 left, actual %0d",
                  $time, owed_replies.size(), owed_replies.size());
      end

      $display("Ran %0d transactions (%0d read outs, %0d pushes into a full queue)",
               items_sent, read_outs, full_rejects);
      $display("and checked %0d replies under three sender idle settings.", replies_seen);
      if (errors == 0)
         $display("[deque_with_search_delete_core] OK");
      else
         $display("[deque_with_search_delete_core] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
